/* sv/pmul_pkg.sv */
// Package for the polynomial multiplier: transaction payload types, controller
// command and status types, state encoding and default sizes.
// No dependencies.
package pmul_pkg;

    localparam int MAX_TERMS_DEF = 16;
    localparam int COEF_BITS_DEF = 32;

    localparam int COEF_W = 32;
    localparam int TDEG_W = 5;
    localparam int PROD_W = 64;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_a;
        logic signed [COEF_W-1:0] coef_b;
        logic                     final_term;
    } in_t;

    typedef struct packed {
        logic [TDEG_W-1:0]        term_degree;
        logic signed [PROD_W-1:0] product_coef;
        logic                     overflow;
        logic                     end_of_product;
    } out_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ISSUE,
        ST_WAIT
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic wr_en;     // store the incoming coefficient pair
        logic issue;     // start one multiply-accumulate term
        logic first;     // term opens a product coefficient
        logic last;      // term closes a product coefficient
        logic load_out;  // move the finished sum into the output register
        logic end_prod;  // result being loaded is the highest degree
        logic overflow;  // pairs were dropped during this load
    } cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic acc_done;  // accumulator holds a finished coefficient
        logic out_free;  // output register can take a result this cycle
    } status_t;

endpackage

/* sv/polynomial_multiply.sv */
// Top level of the polynomial multiplier: ports, controller and datapath.
// Depends on pmul_pkg, pmul_ctrl and pmul_dp.
//
// This block multiplies two integer polynomials by convolving their
// coefficients. Each input transaction carries one coefficient of each
// operand at the same degree, starting at degree 0 and rising by one per
// transaction; the transaction with final_term set closes the load. Only the
// low COEF_BITS bits of each coefficient are used, read as two's complement.
// Up to MAX_TERMS pairs are stored; later pairs of the same load are dropped
// and every result of that product then reports overflow. After the final
// transaction the block returns one result transaction per product degree,
// 0 to 2n-2 for n stored pairs, in ascending order, zero coefficients
// included, with end_of_product set on the last one. Sums wrap at 64 bits
// and term_degree holds the low five bits of the degree. Loading takes one
// transaction per cycle. The product is computed by one shared
// multiply-accumulate unit fed from two single-read-port operand memories,
// one coefficient pair per cycle while a degree's terms are issued, so the
// block stays busy after the final transaction until every degree is done
// (longer while the result side stalls); each degree passes its terms
// through read, multiply and accumulate before its result is loaded. During
// that time s_ready is low. Loading of the next polynomial may start while
// the last result still waits in the output register.
module polynomial_multiply #(
    parameter int MAX_TERMS = pmul_pkg::MAX_TERMS_DEF,
    parameter int COEF_BITS = pmul_pkg::COEF_BITS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  pmul_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output pmul_pkg::out_t  m_data
);

    localparam int IDX_W = $clog2(MAX_TERMS);
    localparam int DEG_W = $clog2(2 * MAX_TERMS - 1);

    pmul_pkg::cmd_t    cmd;
    pmul_pkg::status_t status;
    logic [IDX_W-1:0]  wr_addr;
    logic [IDX_W-1:0]  rd_a_addr;
    logic [IDX_W-1:0]  rd_b_addr;
    logic [DEG_W-1:0]  out_deg;

    // The controller counts stored pairs and walks each product degree over
    // the index range where both operands have a coefficient.
    pmul_ctrl #(
        .MAX_TERMS (MAX_TERMS),
        .IDX_W     (IDX_W),
        .DEG_W     (DEG_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_final   (s_data.final_term),
        .s_ready   (s_ready),
        .status    (status),
        .cmd       (cmd),
        .wr_addr   (wr_addr),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (rd_b_addr),
        .out_deg   (out_deg)
    );

    // The datapath holds the operands, the multiplier, the accumulator and
    // the output register that decouples the result side.
    pmul_dp #(
        .MAX_TERMS (MAX_TERMS),
        .COEF_BITS (COEF_BITS),
        .IDX_W     (IDX_W),
        .DEG_W     (DEG_W)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_a      (s_data.coef_a[COEF_BITS-1:0]),
        .in_b      (s_data.coef_b[COEF_BITS-1:0]),
        .cmd       (cmd),
        .wr_addr   (wr_addr),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (rd_b_addr),
        .out_deg   (out_deg),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

/* sv/pmul_ctrl.sv */
// Controller of the polynomial multiplier: load counting, degree and term
// sequencing. Depends on pmul_pkg.
module pmul_ctrl #(
    parameter int MAX_TERMS = pmul_pkg::MAX_TERMS_DEF,
    parameter int IDX_W     = $clog2(MAX_TERMS),
    parameter int DEG_W     = $clog2(2 * MAX_TERMS - 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_final,
    output logic                  s_ready,
    input  pmul_pkg::status_t     status,
    output pmul_pkg::cmd_t        cmd,
    output logic [IDX_W-1:0]      wr_addr,
    output logic [IDX_W-1:0]      rd_a_addr,
    output logic [IDX_W-1:0]      rd_b_addr,
    output logic [DEG_W-1:0]      out_deg
);

    localparam int CNT_W = $clog2(MAX_TERMS + 1);

    pmul_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [DEG_W-1:0] deg_reg, deg_next;
    logic [IDX_W-1:0] i_reg, i_next;

    logic [DEG_W-1:0] nm1;
    logic [DEG_W-1:0] last_deg;
    logic [DEG_W-1:0] deg_inc;
    logic [IDX_W-1:0] i_lo;
    logic [IDX_W-1:0] i_hi;
    logic             accept;
    logic             room;
    logic             term_last;
    logic             emit;
    logic             prod_end;

    // Lowest term index that contributes to degree d.
    function automatic logic [IDX_W-1:0] lo_of(input logic [DEG_W-1:0] d,
                                                input logic [DEG_W-1:0] m);
        logic [DEG_W-1:0] diff;
        diff = d - m;
        return (d >= m) ? diff[IDX_W-1:0] : '0;
    endfunction

    assign nm1       = DEG_W'(count_reg) - 1'b1;
    assign last_deg  = DEG_W'({count_reg - 1'b1, 1'b0});
    assign deg_inc   = deg_reg + 1'b1;
    assign i_lo      = lo_of(deg_reg, nm1);
    assign i_hi      = (deg_reg < DEG_W'(count_reg)) ? deg_reg[IDX_W-1:0] : nm1[IDX_W-1:0];
    assign accept    = s_valid && s_ready;
    assign room      = count_reg < CNT_W'(MAX_TERMS);
    assign term_last = (i_reg == i_hi);
    assign emit      = status.acc_done && status.out_free;
    assign prod_end  = (deg_reg == last_deg);

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pmul_pkg::ST_LOAD: begin
                if (accept && s_final) begin
                    state_next = pmul_pkg::ST_ISSUE;
                end
            end
            pmul_pkg::ST_ISSUE: begin
                if (term_last) begin
                    state_next = pmul_pkg::ST_WAIT;
                end
            end
            pmul_pkg::ST_WAIT: begin
                if (emit) begin
                    state_next = prod_end ? pmul_pkg::ST_LOAD : pmul_pkg::ST_ISSUE;
                end
            end
            default: state_next = pmul_pkg::ST_LOAD;
        endcase
    end

    // Outputs and counter updates.
    always_comb begin
        s_ready    = 1'b0;
        cmd        = '0;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        deg_next   = deg_reg;
        i_next     = i_reg;
        unique case (state_reg)
            pmul_pkg::ST_LOAD: begin
                s_ready = 1'b1;
                if (accept) begin
                    if (room) begin
                        cmd.wr_en  = 1'b1;
                        count_next = count_reg + 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_final) begin
                        deg_next = '0;
                        i_next   = '0;
                    end
                end
            end
            pmul_pkg::ST_ISSUE: begin
                cmd.issue = 1'b1;
                cmd.first = (i_reg == i_lo);
                cmd.last  = term_last;
                if (!term_last) begin
                    i_next = i_reg + 1'b1;
                end
            end
            pmul_pkg::ST_WAIT: begin
                if (emit) begin
                    cmd.load_out = 1'b1;
                    cmd.end_prod = prod_end;
                    if (prod_end) begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end else begin
                        deg_next = deg_inc;
                        i_next   = lo_of(deg_inc, nm1);
                    end
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
        cmd.overflow = ovf_reg;
    end

    always_comb begin
        logic [DEG_W-1:0] bidx;
        bidx      = deg_reg - DEG_W'(i_reg);
        wr_addr   = count_reg[IDX_W-1:0];
        rd_a_addr = i_reg;
        rd_b_addr = bidx[IDX_W-1:0];
        out_deg   = deg_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pmul_pkg::ST_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            deg_reg   <= '0;
            i_reg     <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            deg_reg   <= deg_next;
            i_reg     <= i_next;
        end
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_TERMS))
        else $error("stored pair count beyond capacity");

    a_compute_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != pmul_pkg::ST_LOAD) |-> (count_reg != '0))
        else $error("product sequencing with no stored pairs");

    a_b_index_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.issue |-> (CNT_W'(rd_b_addr) < count_reg))
        else $error("second operand index outside loaded range");

    a_end_returns: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load_out && cmd.end_prod) |=> (state_reg == pmul_pkg::ST_LOAD && count_reg == '0))
        else $error("controller did not return to loading after the last coefficient");

endmodule

/* sv/pmul_dp.sv */
// Datapath of the polynomial multiplier: operand stores, registered
// multiplier, accumulator and output register. Depends on pmul_pkg.
module pmul_dp #(
    parameter int MAX_TERMS = pmul_pkg::MAX_TERMS_DEF,
    parameter int COEF_BITS = pmul_pkg::COEF_BITS_DEF,
    parameter int IDX_W     = $clog2(MAX_TERMS),
    parameter int DEG_W     = $clog2(2 * MAX_TERMS - 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [COEF_BITS-1:0]  in_a,
    input  logic [COEF_BITS-1:0]  in_b,
    input  pmul_pkg::cmd_t        cmd,
    input  logic [IDX_W-1:0]      wr_addr,
    input  logic [IDX_W-1:0]      rd_a_addr,
    input  logic [IDX_W-1:0]      rd_b_addr,
    input  logic [DEG_W-1:0]      out_deg,
    output pmul_pkg::status_t     status,
    output logic                  m_valid,
    input  logic                  m_ready,
    output pmul_pkg::out_t        m_data
);

    logic [COEF_BITS-1:0] mem_a [MAX_TERMS];
    logic [COEF_BITS-1:0] mem_b [MAX_TERMS];

    logic signed [COEF_BITS-1:0]      rd_a_reg;
    logic signed [COEF_BITS-1:0]      rd_b_reg;
    logic signed [2*COEF_BITS-1:0]    prod_reg;
    logic signed [pmul_pkg::PROD_W-1:0] prod_ext;
    logic signed [pmul_pkg::PROD_W-1:0] acc_reg, acc_next;
    logic s1_valid_reg, s1_first_reg, s1_last_reg;
    logic s2_valid_reg, s2_first_reg, s2_last_reg;
    logic acc_done_reg, acc_done_next;
    logic m_valid_reg, m_valid_next;
    pmul_pkg::out_t out_reg;
    logic out_free;

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem_a[wr_addr] <= in_a;
            mem_b[wr_addr] <= in_b;
        end
        rd_a_reg <= mem_a[rd_a_addr];
        rd_b_reg <= mem_b[rd_b_addr];
    end

    always_ff @(posedge aclk) begin
        prod_reg <= rd_a_reg * rd_b_reg;
    end

    assign prod_ext = pmul_pkg::PROD_W'(prod_reg);
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        acc_next      = acc_reg;
        acc_done_next = acc_done_reg;
        if (s2_valid_reg) begin
            acc_next = s2_first_reg ? prod_ext : acc_reg + prod_ext;
        end
        if (cmd.load_out) begin
            acc_done_next = 1'b0;
        end
        if (s2_valid_reg && s2_last_reg) begin
            acc_done_next = 1'b1;
        end
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (cmd.load_out) begin
            out_reg.term_degree    <= pmul_pkg::TDEG_W'(out_deg);
            out_reg.product_coef   <= acc_reg;
            out_reg.overflow       <= cmd.overflow;
            out_reg.end_of_product <= cmd.end_prod;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_first_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_first_reg <= 1'b0;
            s2_last_reg  <= 1'b0;
            acc_done_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= cmd.issue;
            s1_first_reg <= cmd.first;
            s1_last_reg  <= cmd.last;
            s2_valid_reg <= s1_valid_reg;
            s2_first_reg <= s1_first_reg;
            s2_last_reg  <= s1_last_reg;
            acc_done_reg <= acc_done_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign status.acc_done = acc_done_reg;
    assign status.out_free = out_free;
    assign m_valid         = m_valid_reg;
    assign m_data          = out_reg;

    a_load_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> out_free)
        else $error("result loaded over one not yet taken");

    a_no_term_over_done: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_valid_reg |-> !acc_done_reg)
        else $error("new term accumulated before finished coefficient was taken");

endmodule

/* dv/tb_polynomial_multiply.sv */
// Self-checking testbench for polynomial_multiply: loads coefficient pairs, predicts every
// product coefficient by convolution, and checks the result stream in order.
// Depends on pmul_pkg and polynomial_multiply.
`timescale 1ns / 100ps

module tb_polynomial_multiply;

    // The bench runs the block at its default sizes.
    localparam int MAX_TERMS = pmul_pkg::MAX_TERMS_DEF;
    localparam int COEF_BITS = pmul_pkg::COEF_BITS_DEF;
    localparam int COEF_W    = pmul_pkg::COEF_W;
    localparam int TDEG_W    = pmul_pkg::TDEG_W;

    // Watchdog limit. A sixteen-pair load keeps the block busy through its 31 results, and
    // each of them may sit through a long receiver stall; this limit leaves a wide margin
    // over even the slowest legal run.
    localparam int unsigned CYCLE_LIMIT  = 500_000;
    // Cycles allowed after the last result for anything stray to show up.
    localparam int unsigned TAIL_CYCLES  = 64;
    localparam int unsigned RANDOM_ITEMS = 300;

    localparam logic signed [COEF_W-1:0] COEF_MAX = 32'sh7fff_ffff;
    localparam logic signed [COEF_W-1:0] COEF_MIN = 32'sh8000_0000;

    // Tracks the operand pairs of the load in progress and, when the final pair arrives,
    // computes the whole product. The expected coefficients wait in order until the block
    // returns them.
    class convolution_book;
        longint            a_coef [MAX_TERMS];
        longint            b_coef [MAX_TERMS];
        int unsigned       pairs_held;
        bit                pairs_dropped;
        pmul_pkg::out_t    due_coefs [$];
        int unsigned       mismatches;

        // Keeps the low COEF_BITS bits and reads them as two's complement.
        function automatic longint narrow(input logic signed [COEF_W-1:0] raw);
            longint wide;
            wide = raw;
            return (wide <<< (64 - COEF_BITS)) >>> (64 - COEF_BITS);
        endfunction

        function void absorb_pair(input pmul_pkg::in_t pair);
            int unsigned    n, last, deg, i;
            longint         sum;
            pmul_pkg::out_t coef;
            // A full store drops the pair, even when it is the final one.
            if (pairs_held < MAX_TERMS) begin
                a_coef[pairs_held] = narrow(pair.coef_a);
                b_coef[pairs_held] = narrow(pair.coef_b);
                pairs_held++;
            end else begin
                pairs_dropped = 1'b1;
            end
            if (!pair.final_term) begin
                return;
            end
            n = pairs_held;
            last = 2 * n - 2;
            for (deg = 0; deg <= last; deg++) begin
                sum = 0;
                for (i = 0; i < n; i++) begin
                    if (deg >= i && deg - i < n) begin
                        // longint arithmetic wraps at 64 bits, as the block's sum does.
                        sum += a_coef[i] * b_coef[deg - i];
                    end
                end
                coef.term_degree    = deg[TDEG_W-1:0];
                coef.product_coef   = sum;
                coef.overflow       = pairs_dropped;
                coef.end_of_product = (deg == last);
                due_coefs.push_back(coef);
            end
            pairs_held    = 0;
            pairs_dropped = 1'b0;
        endfunction

        function void check_coef(input pmul_pkg::out_t got);
            pmul_pkg::out_t want;
            if (due_coefs.size() == 0) begin
                $error("unexpected product coefficient: degree %0d, value %0d",
                       got.term_degree, got.product_coef);
                mismatches++;
                return;
            end
            want = due_coefs.pop_front();
            if (got.term_degree !== want.term_degree) begin
                $error("term_degree: expected %0d, got %0d", want.term_degree, got.term_degree);
                mismatches++;
            end
            if (got.product_coef !== want.product_coef) begin
                $error("product_coef: expected %0d, got %0d",
                       want.product_coef, got.product_coef);
                mismatches++;
            end
            if (got.overflow !== want.overflow) begin
                $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
                mismatches++;
            end
            if (got.end_of_product !== want.end_of_product) begin
                $error("end_of_product: expected %0b, got %0b",
                       want.end_of_product, got.end_of_product);
                mismatches++;
            end
        endfunction
    endclass

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    pmul_pkg::in_t    s_data;
    logic             m_valid;
    logic             m_ready;
    pmul_pkg::out_t   m_data;

    convolution_book book = new;

    int unsigned cycle_count = 0;
    int unsigned burst_left  = 0;

    // Receiver pattern: it switches between phases of full throughput, coin-flip
    // readiness, sparse readiness and a complete stall.
    int unsigned ready_mode = 0;
    int unsigned mode_left  = 0;

    polynomial_multiply #(
        .MAX_TERMS (MAX_TERMS),
        .COEF_BITS (COEF_BITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #1 aclk = ~aclk;

    // The watchdog ends a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode <= $urandom_range(0, 3);
                mode_left  <= $urandom_range(5, 40);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (ready_mode)
                0: begin
                    m_ready <= 1'b1;
                end
                1: begin
                    m_ready <= 1'($urandom_range(0, 1));
                end
                2: begin
                    m_ready <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    m_ready <= 1'b0;
                end
            endcase
        end
    end

    // Result monitor. The values seen here are those present at the clock edge, since every
    // driver updates through nonblocking assignments.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            book.check_coef(m_data);
        end
    end

    // Sender pacing: bursts of random length, mostly short, sometimes long, separated by
    // random gaps. Valid drops only after an accepted transaction, never during one.
    task automatic pace_sender();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 8);
        end
    endtask

    // Presents one coefficient pair and holds it until the block takes it.
    task automatic send_pair(input pmul_pkg::in_t pair);
        s_data  <= pair;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        book.absorb_pair(pair);
        pace_sender();
    endtask

    // Holds off the sender until the block has returned every outstanding coefficient.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (book.due_coefs.size() != 0) @(posedge aclk);
    endtask

    // Coefficient mix: the extremes and zero show up often, so that sums wrap and zero
    // products appear; the rest is spread over the whole range.
    function automatic logic signed [COEF_W-1:0] pick_coef();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return COEF_MAX;
            2: return COEF_MIN;
            3: return -1;
            4: return $urandom_range(0, 200) - 100;
            default: return $urandom;
        endcase
    endfunction

    // Load length: mostly short polynomials, some mid-sized, a few that fill the store,
    // and a few that run past it.
    function automatic int unsigned pick_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            return $urandom_range(1, 4);
        end else if (roll < 90) begin
            return $urandom_range(5, MAX_TERMS - 1);
        end else if (roll < 96) begin
            return MAX_TERMS;
        end
        return $urandom_range(MAX_TERMS + 1, MAX_TERMS + 4);
    endfunction

    task automatic send_load(input int unsigned len);
        pmul_pkg::in_t pair;
        for (int unsigned k = 0; k < len; k++) begin
            pair.coef_a     = pick_coef();
            pair.coef_b     = pick_coef();
            pair.final_term = (k == len - 1);
            send_pair(pair);
        end
    endtask

    initial begin
        pmul_pkg::in_t pair;
        int unsigned   random_items;
        int unsigned   len;

        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Single-term products at the extremes: the most negative value squared, then
        // the largest positive times the most negative.
        pair = '{coef_a: COEF_MIN, coef_b: COEF_MIN, final_term: 1'b1};
        send_pair(pair);
        pair = '{coef_a: COEF_MAX, coef_b: COEF_MIN, final_term: 1'b1};
        send_pair(pair);

        // Two terms with mixed signs.
        pair = '{coef_a: COEF_MAX, coef_b: -1, final_term: 1'b0};
        send_pair(pair);
        pair = '{coef_a: 0, coef_b: COEF_MAX, final_term: 1'b1};
        send_pair(pair);

        // Sparse operands: several product coefficients come out as zero and must still be
        // returned.
        pair = '{coef_a: 1, coef_b: 0, final_term: 1'b0};
        send_pair(pair);
        pair = '{coef_a: 0, coef_b: 0, final_term: 1'b0};
        send_pair(pair);
        pair = '{coef_a: 0, coef_b: 1, final_term: 1'b1};
        send_pair(pair);
        wait_drained();

        // A full store of the most negative value makes the middle sums wrap. The final pair
        // arrives with the store full, so it is dropped, the product still runs on the
        // stored pairs, and every result reports overflow.
        for (int unsigned k = 0; k < MAX_TERMS; k++) begin
            pair = '{coef_a: COEF_MIN, coef_b: COEF_MIN, final_term: 1'b0};
            send_pair(pair);
        end
        pair = '{coef_a: COEF_MAX, coef_b: COEF_MAX, final_term: 1'b1};
        send_pair(pair);
        wait_drained();

        // Random loads. Now and then the sender holds off until the block has emptied,
        // so that a fresh load starts from a quiet block as well as on a busy one.
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            len = pick_length();
            send_load(len);
            random_items += len;
            if ($urandom_range(0, 9) == 0) begin
                wait_drained();
            end
        end

        // Let every expected coefficient arrive (the watchdog bounds the wait), then leave
        // some idle cycles so that any extra result would be caught.
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (book.mismatches == 0 && book.due_coefs.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
